>>> hdl/ogb_pkg.sv
// Shared types and constants for the octave Goertzel bank.
package ogb_pkg;
   localparam int unsigned HIST_W = 16;
   localparam int unsigned MAG_W = 24;
   localparam logic [15:0] COEF_RESET = 16'd62328;
   localparam logic [7:0] BLEN_RESET = 8'd20;
   localparam logic [7:0] DECAY_RESET = 8'd100;
   localparam logic [3:0] SHIFT_MAX = 4'd10;
   localparam logic [1:0] REG_COEF = 2'd0;
   localparam logic [1:0] REG_BLEN = 2'd1;
   localparam logic [1:0] REG_DECAY = 2'd2;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_UPD    = 7'b0000010,
      ST_UPD2   = 7'b0000100,
      ST_NORM   = 7'b0001000,
      ST_MAG    = 7'b0010000,
      ST_MAG2   = 7'b0100000,
      ST_OUT    = 7'b1000000
   } state_type;
endpackage

>>> hdl/octave_goertzel_bank.sv
// Top level: octave Goertzel bank with one shared multiplier and a sequencer.
// Per sample: each bin runs ST_UPD then ST_UPD2, ST_NORM scans every bin then
// applies the shift, and the sequencer returns to idle; a completing sample adds
// ST_MAG and ST_MAG2 work per bin, then ST_OUT beats that hold while the result
// side stalls. req_stall is high while busy; samples are taken only in idle.
// Synchronous active-high reset clears histories and counts and loads the CSR registers with their reset values.
module octave_goertzel_bank #(
   parameter int unsigned BINS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [9:0]  req_sample,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_bin_index,
   output logic signed [23:0] rsp_magnitude,
   output logic [3:0]  rsp_block_scale,
   output logic        rsp_last,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   localparam int unsigned BW = (BINS > 1) ? $clog2(BINS) : 1;

   ogb_pkg::state_type state_ff, state_in;
   logic [15:0] coef_ff;
   logic [7:0]  blen_ff, decay_ticks_ff, decay_ff;
   logic [3:0]  shift_ff;
   logic [15:0] scount_ff;
   logic [9:0]  samp_ff;
   logic signed [15:0] q1_ff [BINS];
   logic signed [15:0] q2_ff [BINS];
   logic [7:0]  ucnt_ff [BINS];
   logic [BW-1:0] idx_ff;
   logic [6:0]  mmax_ff;
   logic signed [17:0] tq_ff;
   logic signed [47:0] acc_ff;
   logic [1:0]  mph_ff;

   // shared multiplier: 17x17 signed
   logic signed [16:0] mul_a, mul_b;
   logic signed [33:0] mul_p;
   assign mul_p = mul_a * mul_b;

   logic [15:0] toggles;
   assign toggles = (scount_ff + 16'd1) ^ scount_ff;

   logic signed [15:0] cq1, cq2, csel;
   logic [15:0] cmag;
   logic [31:0] cprod;
   assign cq1 = q1_ff[idx_ff];
   assign cq2 = q2_ff[idx_ff];
   assign csel = (state_ff == ogb_pkg::ST_MAG) ? cq2 : cq1;
   assign cmag = csel[15] ? 16'(-csel) : csel;
   assign cprod = mul_p[31:0];

   logic bin_upd;
   assign bin_upd = toggles[idx_ff] && (ucnt_ff[idx_ff] < blen_ff);

   logic [9:0] sh_samp;
   assign sh_samp = samp_ff >> shift_ff;

   logic [15:0] newv;
   assign newv = 16'(tq_ff <<< 1) - cq2 + 16'(sh_samp);

   logic [15:0] absq;
   logic [5:0] vcand;
   assign absq = cq1[15] ? ~cq1 : cq1;
   assign vcand = absq[15:10];

   logic last_bin;
   assign last_bin = (idx_ff == BW'(BINS - 1));

   always_comb begin
      mul_a = 17'sd0;
      mul_b = 17'sd0;
      if (state_ff == ogb_pkg::ST_UPD || state_ff == ogb_pkg::ST_MAG) begin
         mul_a = $signed({1'b0, cmag});
         mul_b = $signed({1'b0, coef_ff});
      end else begin
         case (mph_ff)
            2'd0: begin mul_a = 17'(cq1); mul_b = 17'(cq1); end
            2'd1: begin mul_a = 17'(cq2); mul_b = 17'(cq2); end
            default: begin mul_a = tq_ff[16:0]; mul_b = 17'(cq1); end
         endcase
      end
   end

   logic signed [47:0] mag_sat_src;
   logic signed [23:0] mag_sat;
   assign mag_sat_src = acc_ff;
   always_comb begin
      if (mag_sat_src > 48'sd8388607) mag_sat = 24'sh7FFFFF;
      else if (mag_sat_src < -48'sd8388608) mag_sat = -24'sh800000;
      else mag_sat = mag_sat_src[23:0];
   end

   logic signed [23:0] mag_ff [BINS];
   logic [3:0] bscale_ff;

   assign req_stall = (state_ff != ogb_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == ogb_pkg::ST_OUT);
   assign rsp_bin_index = 3'(idx_ff);
   assign rsp_magnitude = mag_ff[idx_ff];
   assign rsp_block_scale = bscale_ff;
   assign rsp_last = last_bin;

   logic [10:0] shsum;
   assign shsum = 11'(shift_ff) + 11'(mmax_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ogb_pkg::ST_IDLE;
         coef_ff <= ogb_pkg::COEF_RESET;
         blen_ff <= ogb_pkg::BLEN_RESET;
         decay_ticks_ff <= ogb_pkg::DECAY_RESET;
         decay_ff <= '0;
         shift_ff <= '0;
         scount_ff <= '0;
         idx_ff <= '0;
         mmax_ff <= '0;
         mph_ff <= '0;
         for (int i = 0; i < BINS; i++) begin
            q1_ff[i] <= '0;
            q2_ff[i] <= '0;
            ucnt_ff[i] <= '0;
         end
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               ogb_pkg::REG_COEF: coef_ff <= csr_data;
               ogb_pkg::REG_BLEN: blen_ff <= csr_data[7:0];
               ogb_pkg::REG_DECAY: decay_ticks_ff <= csr_data[7:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            ogb_pkg::ST_IDLE: begin
               if (req_valid) begin
                  samp_ff <= req_sample;
                  idx_ff <= '0;
                  state_ff <= ogb_pkg::ST_UPD;
               end
            end
            ogb_pkg::ST_UPD: begin
               tq_ff <= cq1[15] ? -18'(cprod[31:16]) : 18'(cprod[31:16]);
               state_ff <= ogb_pkg::ST_UPD2;
            end
            ogb_pkg::ST_UPD2: begin
               if (bin_upd) begin
                  q2_ff[idx_ff] <= cq1;
                  q1_ff[idx_ff] <= newv;
                  ucnt_ff[idx_ff] <= ucnt_ff[idx_ff] + 8'd1;
               end
               if (last_bin) begin
                  idx_ff <= '0;
                  mmax_ff <= '0;
                  state_ff <= ogb_pkg::ST_NORM;
               end else begin
                  idx_ff <= idx_ff + BW'(1);
                  state_ff <= ogb_pkg::ST_UPD;
               end
            end
            ogb_pkg::ST_NORM: begin
               // scan pass over bins then an apply step (idx wraps)
               if (mph_ff == 2'd0) begin
                  if (7'(vcand) > mmax_ff) mmax_ff <= 7'(vcand);
                  if (last_bin) begin
                     mph_ff <= 2'd1;
                     idx_ff <= '0;
                  end else idx_ff <= idx_ff + BW'(1);
               end else begin
                  mph_ff <= 2'd0;
                  if (mmax_ff != 7'd0) begin
                     for (int i = 0; i < BINS; i++) begin
                        q1_ff[i] <= q1_ff[i] >>> mmax_ff;
                        q2_ff[i] <= q2_ff[i] >>> mmax_ff;
                     end
                     shift_ff <= (shsum > 11'(ogb_pkg::SHIFT_MAX)) ?
                        ogb_pkg::SHIFT_MAX : shsum[3:0];
                     decay_ff <= '0;
                  end
                  if (ucnt_ff[BINS-1] >= blen_ff) begin
                     scount_ff <= '0;
                     idx_ff <= '0;
                     state_ff <= ogb_pkg::ST_MAG;
                  end else begin
                     scount_ff <= scount_ff + 16'd1;
                     state_ff <= ogb_pkg::ST_IDLE;
                  end
               end
            end
            ogb_pkg::ST_MAG: begin
               tq_ff <= cq2[15] ? -18'(cprod[31:16]) : 18'(cprod[31:16]);
               mph_ff <= 2'd0;
               acc_ff <= '0;
               state_ff <= ogb_pkg::ST_MAG2;
            end
            ogb_pkg::ST_MAG2: begin
               if (mph_ff == 2'd2) acc_ff <= acc_ff - 48'(mul_p <<< 1);
               else if (mph_ff != 2'd3) acc_ff <= acc_ff + 48'(mul_p);
               if (mph_ff == 2'd2) begin
                  mph_ff <= 2'd3;
               end else if (mph_ff == 2'd3) begin
                  mph_ff <= 2'd0;
                  mag_ff[idx_ff] <= mag_sat;
                  if (last_bin) begin
                     idx_ff <= '0;
                     bscale_ff <= shift_ff;
                     for (int i = 0; i < BINS; i++) begin
                        q1_ff[i] <= '0;
                        q2_ff[i] <= '0;
                        ucnt_ff[i] <= '0;
                     end
                     if (decay_ff + 8'd1 >= decay_ticks_ff) begin
                        decay_ff <= '0;
                        if (shift_ff != 4'd0) shift_ff <= shift_ff - 4'd1;
                     end else decay_ff <= decay_ff + 8'd1;
                     state_ff <= ogb_pkg::ST_OUT;
                  end else begin
                     idx_ff <= idx_ff + BW'(1);
                     state_ff <= ogb_pkg::ST_MAG;
                  end
               end else mph_ff <= mph_ff + 2'd1;
            end
            ogb_pkg::ST_OUT: begin
               if (!rsp_stall) begin
                  if (last_bin) begin
                     idx_ff <= '0;
                     state_ff <= ogb_pkg::ST_IDLE;
                  end else idx_ff <= idx_ff + BW'(1);
               end
            end
            default: state_ff <= ogb_pkg::ST_IDLE;
         endcase
      end
   end
endmodule
